FILE: sv/pcx_rle_row_decoder_defines.svh
// Assertion macros shared by the PCX run-length row decoder modules.
`ifndef PCX_RLE_ROW_DECODER_DEFINES_SVH
`define PCX_RLE_ROW_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define PRD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PRD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PRD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/prd_pkg.sv
// Shared types and constants of the PCX run-length row decoder.
`timescale 1ns / 1ps
package prd_pkg;
   localparam logic        CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic        CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [1:0]  CODE_MARK        = 2'b11;
   localparam logic [15:0] WIDTH_RESET      = 16'd640;
   localparam logic [15:0] HEIGHT_RESET     = 16'd480;
   localparam int          MAX_RUN          = 63;
   localparam int          RUN_W            = $clog2(MAX_RUN + 1);

   typedef struct packed {
      logic take;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic multi;
      logic last_step;
   } status_type;
endpackage

FILE: sv/pcx_rle_row_decoder.sv
// The first pixel of a byte appears on rsp in the cycle after the byte is accepted.
// While the output register is free: one literal byte per cycle; a count byte sets N, and
// its colour byte holds the input for N kept pixels, one per cycle through that register.
// The output register takes a new pixel whenever it is empty or being drained.
// Reset (synchronous): position, row and pending count clear; width 640, height 480.
`timescale 1ns / 1ps
module pcx_rle_row_decoder
   import prd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pixel_value, pixel_column, pixel_row
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // image_done
);
   cmd_type    cmd;
   status_type status;

   prd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

FILE: sv/prd_ctrl.sv
// Controller of the PCX run-length row decoder: accept and run sequencing.
`timescale 1ns / 1ps
`include "pcx_rle_row_decoder_defines.svh"
module prd_ctrl
   import prd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free;
            if (req_tvalid && status.out_free) begin
               cmd.take = 1'b1;
               if (status.multi) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.last_step) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PRD_ASSERT_NEXT(a_run_after_multi, clock, reset, cmd.take && status.multi, state_ff == ST_RUN)
   `PRD_ASSERT_IMPLIES(a_load_when_free, clock, reset, cmd.take || cmd.step, status.out_free)
   `PRD_ASSERT_NEXT(a_idle_after_last, clock, reset, cmd.step && status.last_step, state_ff == ST_IDLE)
endmodule

FILE: sv/prd_datapath.sv
// Datapath of the PCX run-length row decoder: position, run and output registers.
`timescale 1ns / 1ps
`include "pcx_rle_row_decoder_defines.svh"
module prd_datapath
   import prd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic [7:0]  req_tdata,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tuser
);
   logic [15:0]      width_ff, height_ff;
   logic             count_pending_ff;
   logic [RUN_W-1:0] held_count_ff;
   logic [16:0]      column_ff;
   logic [15:0]      row_ff;
   logic             finished_ff;

   logic [7:0]       run_value_ff;
   logic [15:0]      run_col_ff;
   logic [15:0]      run_row_ff;
   logic [RUN_W-1:0] run_left_ff;
   logic             run_done_ff;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_value_ff;
   logic [15:0]      out_col_ff;
   logic [15:0]      out_row_ff;
   logic             out_last_ff;
   logic             out_done_ff;

   logic             skip, is_code, wrap, done_now, in_row;
   logic [RUN_W-1:0] amount, emit;
   logic [16:0]      stride, sum, diff, width_x;
   logic [15:0]      row_next;

   always_comb begin
      width_x  = {1'b0, width_ff};
      skip     = finished_ff || (row_ff >= height_ff);
      is_code  = !count_pending_ff && (req_tdata[7:6] == CODE_MARK);
      amount   = count_pending_ff ? held_count_ff : RUN_W'(1);
      stride   = width_x + 17'(width_ff[0]);
      sum      = column_ff + 17'(amount);
      wrap     = sum >= stride;
      row_next = row_ff + 16'd1;
      done_now = wrap && (row_next >= height_ff);
      in_row   = column_ff < width_x;
      diff     = width_x - column_ff;
      if (skip || is_code || !in_row) begin
         emit = '0;
      end else if (diff < 17'(amount)) begin
         emit = diff[RUN_W-1:0];
      end else begin
         emit = amount;
      end
   end

   assign status.out_free  = !out_valid_ff || rsp_tready;
   assign status.multi     = emit > RUN_W'(1);
   assign status.last_step = run_left_ff == RUN_W'(1);

   always_comb begin
      priority if (cmd.take && (emit != '0)) begin
         out_valid_in = 1'b1;
      end else if (cmd.step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff         <= WIDTH_RESET;
         height_ff        <= HEIGHT_RESET;
         count_pending_ff <= 1'b0;
         held_count_ff    <= '0;
         column_ff        <= '0;
         row_ff           <= '0;
         finished_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         run_left_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default:          ;
            endcase
         end
         if (cmd.take && !skip) begin
            if (is_code) begin
               held_count_ff    <= req_tdata[RUN_W-1:0];
               count_pending_ff <= 1'b1;
            end else begin
               count_pending_ff <= 1'b0;
               column_ff        <= wrap ? 17'd0 : sum;
               row_ff           <= wrap ? row_next : row_ff;
               finished_ff      <= finished_ff || done_now;
            end
         end
         if (cmd.take) begin
            run_left_ff <= (emit == '0) ? '0 : emit - RUN_W'(1);
         end else if (cmd.step) begin
            run_left_ff <= run_left_ff - RUN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         run_value_ff <= req_tdata;
         run_col_ff   <= column_ff[15:0] + 16'd1;
         run_row_ff   <= row_ff;
         run_done_ff  <= done_now;
         out_value_ff <= req_tdata;
         out_col_ff   <= column_ff[15:0];
         out_row_ff   <= row_ff;
         out_last_ff  <= emit == RUN_W'(1);
         out_done_ff  <= done_now;
      end else if (cmd.step) begin
         run_col_ff   <= run_col_ff + 16'd1;
         out_value_ff <= run_value_ff;
         out_col_ff   <= run_col_ff;
         out_row_ff   <= run_row_ff;
         out_last_ff  <= run_left_ff == RUN_W'(1);
         out_done_ff  <= run_done_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_row_ff, out_col_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   `PRD_ASSERT_IMPLIES(a_step_has_run, clock, reset, cmd.step, run_left_ff != '0)
   `PRD_ASSERT_IMPLIES(a_done_at_col0, clock, reset, finished_ff, column_ff == '0)
   `PRD_ASSERT_NEXT(a_finish_sticks, clock, reset, finished_ff && !csr_we, finished_ff)
endmodule
